// ===== design/minmax_normalize_upscale_unit_defines.svh =====
// assertion macros used by the checker file mnu_checker
// no dependencies; expects clk and rst_n in the scope of use
`ifndef MINMAX_NORMALIZE_UPSCALE_UNIT_DEFINES_SVH
`define MINMAX_NORMALIZE_UPSCALE_UNIT_DEFINES_SVH

// consequent checked in the same cycle
`define MNU_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// consequent checked in the next cycle
`define MNU_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== design/mnu_pkg.sv =====
// types and fixed constants of the min-max normalize and upscale unit
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package mnu_pkg;

    typedef struct packed {
        logic               opcode;
        logic signed [15:0] sample;
    } in_item_t;

    typedef struct packed {
        logic [7:0] pixel_byte;
        logic       frame_end;
    } out_item_t;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_PULL = 1'b1;

    localparam logic [1:0] REG_COLS  = 2'd0;
    localparam logic [1:0] REG_ROWS  = 2'd1;
    localparam logic [1:0] REG_SCALE = 2'd2;
    localparam logic [1:0] REG_COLOR = 2'd3;

    localparam int NUM_W  = 31;
    localparam int DEN_W  = 23;
    localparam int QUOT_W = 8;
    localparam int LIN_W  = 21;
    localparam int ADDR_W = 23;

    localparam logic [NUM_W-1:0] NUM_GAIN = 31'd25499;
    localparam logic [DEN_W-1:0] DEN_GAIN = 23'd100;
    localparam logic [7:0]       BYTE_MAX = 8'd254;
    localparam logic [10:0]      DIM_MAX  = 11'd1024;

    function automatic logic [10:0] clamp_dim(input logic [10:0] v);
        logic [10:0] r;
        if (v == 11'd0)
        begin
            r = 11'd1;
        end
        else if (v > DIM_MAX)
        begin
            r = DIM_MAX;
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== design/mnu_ram.sv =====
// generic single-port ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module mnu_ram #(
    parameter int WIDTH  = 16,
    parameter int DEPTH  = 65536,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] addr,
    input  wire logic [WIDTH-1:0]  wdata,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

`default_nettype wire

// ===== design/mnu_div.sv =====
// restoring divider, one quotient bit per cycle
// depends on mnu_pkg
`timescale 1ns / 1ps
`default_nettype none

module mnu_div (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic [mnu_pkg::NUM_W-1:0] num,
    input  wire logic [mnu_pkg::DEN_W-1:0] den,
    output logic                           done,
    output logic [mnu_pkg::QUOT_W-1:0]     quot
);

    import mnu_pkg::*;

    logic [NUM_W-1:0]  rem_reg;
    logic [NUM_W-1:0]  dsh_reg;
    logic [QUOT_W-1:0] q_reg;
    logic [2:0]        cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic              fit;

    assign fit  = rem_reg >= dsh_reg;
    assign done = done_reg;
    assign quot = q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 3'd0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == 3'd0);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 3'd7;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 3'd1;
                if (cnt_reg == 3'd0)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= num;
            dsh_reg <= NUM_W'({den, 7'b0});
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            if (fit)
            begin
                rem_reg <= rem_reg - dsh_reg;
            end
            q_reg   <= {q_reg[QUOT_W-2:0], fit};
            dsh_reg <= dsh_reg >> 1;
        end
    end

endmodule

`default_nettype wire

// ===== design/minmax_normalize_upscale_unit.sv =====
// load item: loads may follow back to back
// pull item: runs from accept to result through the address multiply, the ram read and the divider
// a pull whose byte clamps or whose frame is flat skips the divider and goes from the ram read to the output
// one pull is in flight at a time; input stalls until its result enters the output register
// reset (async, active low) clears min/max, counters and phase; the frame ram is not cleared
// depends on mnu_pkg, mnu_ram, mnu_div
`timescale 1ns / 1ps
`default_nettype none

module minmax_normalize_upscale_unit #(
    parameter int MAX_SAMPLES = 65536,
    parameter int MAX_SCALE   = 8
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire mnu_pkg::in_item_t  in_data,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output mnu_pkg::out_item_t      out_data,
    input  wire logic               cfg_we,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [10:0]        cfg_data
);

    import mnu_pkg::*;

    localparam int AW  = $clog2(MAX_SAMPLES);
    localparam int LCW = AW + 1;
    localparam int SW  = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_ADDR = 3'd2;
    localparam logic [2:0] S_READ = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;
    localparam logic [2:0] S_NORM = 3'd6;

    // configuration
    logic [10:0] cols_cfg_reg;
    logic [10:0] rows_cfg_reg;
    logic [3:0]  scale_cfg_reg;
    logic        color_cfg_reg;

    // frame state
    logic signed [15:0] low_reg;
    logic signed [15:0] high_reg;
    logic [LCW-1:0]     load_cnt_reg;
    logic               emitting_reg;
    logic [9:0]         row_reg;
    logic [SW-1:0]      row_rep_reg;
    logic [9:0]         col_reg;
    logic [SW-1:0]      col_rep_reg;
    logic [1:0]         ch_reg;

    // pull item in flight
    logic [2:0]         state_reg;
    logic [9:0]         row_q_reg;
    logic [9:0]         col_q_reg;
    logic [1:0]         ch_q_reg;
    logic [10:0]        cols_q_reg;
    logic               color_q_reg;
    logic signed [15:0] lo_q_reg;
    logic signed [15:0] hi_q_reg;
    logic               end_q_reg;
    logic [LIN_W-1:0]   rc_reg;
    logic               oob_reg;
    logic [NUM_W-1:0]   num_reg;
    logic [DEN_W-1:0]   den_reg;
    logic [7:0]         byte_reg;

    logic      out_valid_reg;
    out_item_t out_data_reg;

    // counter advance
    logic [10:0] cols_c;
    logic [10:0] rows_c;
    logic [5:0]  scale_c;
    logic [2:0]  chans_c;
    logic        ch_last, cr_last, col_last, rr_last, row_last, frame_last;
    logic [1:0]  ch_next;
    logic [SW-1:0] col_rep_next;
    logic [SW-1:0] row_rep_next;
    logic [9:0]  col_next;
    logic [9:0]  row_next;

    // address and normalize
    logic [LIN_W-1:0]   lin;
    logic [ADDR_W-1:0]  addr;
    logic [AW-1:0]      ram_addr;
    logic               ram_we;
    logic [15:0]        ram_rdata;
    logic signed [15:0] x;
    logic [15:0]        dx;
    logic [15:0]        dr;
    logic               special;
    logic [7:0]         special_byte;

    logic              div_start;
    logic              div_done;
    logic [QUOT_W-1:0] div_quot;

    logic take_in;
    logic is_pull;
    logic do_load;
    logic out_free;

    assign take_in  = in_valid && !in_stall;
    assign is_pull  = in_data.opcode == OP_PULL;
    assign do_load  = take_in && !is_pull && !emitting_reg
                      && (load_cnt_reg < LCW'(MAX_SAMPLES));
    assign in_stall = state_reg != S_IDLE;
    assign out_free = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // limits
    assign cols_c  = clamp_dim(cols_cfg_reg);
    assign rows_c  = clamp_dim(rows_cfg_reg);
    assign scale_c = (scale_cfg_reg == 4'd0) ? 6'd1 :
                     (6'(scale_cfg_reg) > 6'(MAX_SCALE)) ? 6'(MAX_SCALE) : 6'(scale_cfg_reg);
    assign chans_c = color_cfg_reg ? 3'd3 : 3'd1;

    assign ch_last    = (3'(ch_reg) + 3'd1) >= chans_c;
    assign cr_last    = (6'(col_rep_reg) + 6'd1) >= scale_c;
    assign col_last   = (11'(col_reg) + 11'd1) >= cols_c;
    assign rr_last    = (6'(row_rep_reg) + 6'd1) >= scale_c;
    assign row_last   = (11'(row_reg) + 11'd1) >= rows_c;
    assign frame_last = ch_last && cr_last && col_last && rr_last && row_last;

    always_comb
    begin
        ch_next      = ch_reg;
        col_rep_next = col_rep_reg;
        col_next     = col_reg;
        row_rep_next = row_rep_reg;
        row_next     = row_reg;
        if (ch_last)
        begin
            ch_next = 2'd0;
            if (cr_last)
            begin
                col_rep_next = '0;
                if (col_last)
                begin
                    col_next = 10'd0;
                    if (rr_last)
                    begin
                        row_rep_next = '0;
                        row_next     = row_last ? 10'd0 : row_reg + 10'd1;
                    end
                    else
                    begin
                        row_rep_next = row_rep_reg + SW'(1);
                    end
                end
                else
                begin
                    col_next = col_reg + 10'd1;
                end
            end
            else
            begin
                col_rep_next = col_rep_reg + SW'(1);
            end
        end
        else
        begin
            ch_next = ch_reg + 2'd1;
        end
    end

    // store address
    assign lin  = rc_reg + LIN_W'(col_q_reg);
    assign addr = color_q_reg ? ((ADDR_W'(lin) << 1) + ADDR_W'(lin) + ADDR_W'(ch_q_reg))
                              : (ADDR_W'(lin) + ADDR_W'(ch_q_reg));
    assign ram_we   = do_load;
    assign ram_addr = (state_reg == S_ADDR) ? addr[AW-1:0] : load_cnt_reg[AW-1:0];

    mnu_ram #(
        .WIDTH (16),
        .DEPTH (MAX_SAMPLES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (in_data.sample),
        .rdata (ram_rdata)
    );

    // normalize
    assign x  = oob_reg ? 16'sd0 : $signed(ram_rdata);
    assign dx = 16'(17'(x) - 17'(lo_q_reg));
    assign dr = 16'(17'(hi_q_reg) - 17'(lo_q_reg));

    always_comb
    begin
        special      = 1'b1;
        special_byte = 8'd0;
        if (hi_q_reg <= lo_q_reg)
        begin
            special_byte = 8'd0;
        end
        else if (x <= lo_q_reg)
        begin
            special_byte = 8'd0;
        end
        else if (x >= hi_q_reg)
        begin
            special_byte = BYTE_MAX;
        end
        else
        begin
            special = 1'b0;
        end
    end

    assign div_start = state_reg == S_NORM;

    mnu_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num_reg),
        .den   (den_reg),
        .done  (div_done),
        .quot  (div_quot)
    );

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_cfg_reg  <= 11'd256;
            rows_cfg_reg  <= 11'd256;
            scale_cfg_reg <= 4'd1;
            color_cfg_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_COLS:  cols_cfg_reg  <= cfg_data;
                REG_ROWS:  rows_cfg_reg  <= cfg_data;
                REG_SCALE: scale_cfg_reg <= cfg_data[3:0];
                REG_COLOR: color_cfg_reg <= cfg_data[0];
                default:   ;
            endcase
        end
    end

    // frame state and control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_reg       <= 16'sh7FFF;
            high_reg      <= -16'sh8000;
            load_cnt_reg  <= '0;
            emitting_reg  <= 1'b0;
            row_reg       <= 10'd0;
            row_rep_reg   <= '0;
            col_reg       <= 10'd0;
            col_rep_reg   <= '0;
            ch_reg        <= 2'd0;
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall && state_reg != S_DONE)
            begin
                out_valid_reg <= 1'b0;
            end
            if (do_load)
            begin
                load_cnt_reg <= load_cnt_reg + LCW'(1);
                if (in_data.sample < low_reg)
                begin
                    low_reg <= in_data.sample;
                end
                if (in_data.sample > high_reg)
                begin
                    high_reg <= in_data.sample;
                end
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (take_in && is_pull)
                    begin
                        state_reg <= S_MUL;
                        if (frame_last)
                        begin
                            low_reg      <= 16'sh7FFF;
                            high_reg     <= -16'sh8000;
                            load_cnt_reg <= '0;
                            emitting_reg <= 1'b0;
                            row_reg      <= 10'd0;
                            row_rep_reg  <= '0;
                            col_reg      <= 10'd0;
                            col_rep_reg  <= '0;
                            ch_reg       <= 2'd0;
                        end
                        else
                        begin
                            emitting_reg <= 1'b1;
                            row_reg      <= row_next;
                            row_rep_reg  <= row_rep_next;
                            col_reg      <= col_next;
                            col_rep_reg  <= col_rep_next;
                            ch_reg       <= ch_next;
                        end
                    end
                end
                S_MUL:  state_reg <= S_ADDR;
                S_ADDR: state_reg <= S_READ;
                S_READ: state_reg <= special ? S_DONE : S_NORM;
                S_NORM: state_reg <= S_DIV;
                S_DIV:
                begin
                    if (div_done)
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // pull payload
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && take_in && is_pull)
        begin
            row_q_reg   <= row_reg;
            col_q_reg   <= col_reg;
            ch_q_reg    <= ch_reg;
            cols_q_reg  <= cols_c;
            color_q_reg <= color_cfg_reg;
            lo_q_reg    <= low_reg;
            hi_q_reg    <= high_reg;
            end_q_reg   <= frame_last;
        end
        if (state_reg == S_MUL)
        begin
            rc_reg <= LIN_W'(row_q_reg) * LIN_W'(cols_q_reg);
        end
        if (state_reg == S_ADDR)
        begin
            oob_reg <= addr >= ADDR_W'(MAX_SAMPLES);
        end
        if (state_reg == S_READ)
        begin
            num_reg  <= NUM_W'(dx) * NUM_GAIN;
            den_reg  <= DEN_W'(dr) * DEN_GAIN;
            byte_reg <= special_byte;
        end
        if (state_reg == S_DIV && div_done)
        begin
            byte_reg <= div_quot;
        end
        if (state_reg == S_DONE && out_free)
        begin
            out_data_reg.pixel_byte <= byte_reg;
            out_data_reg.frame_end  <= end_q_reg;
        end
    end

endmodule

`default_nettype wire

// ===== design/mnu_checker.sv =====
// port-level checks for the min-max normalize and upscale unit, bound to the top level
// depends on mnu_pkg and minmax_normalize_upscale_unit_defines.svh
`timescale 1ns / 1ps
`default_nettype none

`include "minmax_normalize_upscale_unit_defines.svh"

module mnu_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_valid,
    input wire logic               in_stall,
    input wire mnu_pkg::in_item_t  in_data,
    input wire logic               out_valid,
    input wire logic               out_stall,
    input wire mnu_pkg::out_item_t out_data
);

    import mnu_pkg::*;

    // a stalled result holds
    `MNU_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))

    // a pull item blocks the input while it is worked on
    `MNU_ASSERT_NEXT(a_pull_blocks, in_valid && !in_stall && in_data.opcode == OP_PULL, in_stall)

    // a new result only appears while a pull is in flight
    `MNU_ASSERT_NOW(a_result_from_pull, $rose(out_valid), $past(in_stall))

    // bytes never exceed the top of the range
    `MNU_ASSERT_NOW(a_byte_range, out_valid, out_data.pixel_byte <= BYTE_MAX)

endmodule

bind minmax_normalize_upscale_unit mnu_checker u_mnu_checker (.*);

`default_nettype wire
